// ----- src/gwm_pkg.sv -----
// gwm_pkg: shared types, constants and helpers of the glob wildcard matcher
// no dependencies
package gwm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int AW = $clog2(MAX_PATTERN);
    // position index: holds 0 .. MAX_PATTERN + 1
    localparam int PW = $clog2(MAX_PATTERN + 2);
    // class cursor: may run a few entries past the end
    localparam int CW = PW + 1;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_BSLSH = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_MATCH = 1'b1;

    localparam logic [1:0] VD_MATCH    = 2'd0;
    localparam logic [1:0] VD_EXCLUDED = 2'd1;
    localparam logic [1:0] VD_NOMATCH  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_OP,
        S_ESC,
        S_C_BANG,
        S_C_FIRST,
        S_C_TOP,
        S_C_LOOK,
        S_C_HI,
        S_C_AFTER,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        P_CLOS1,
        P_ADV_B,
        P_CLOS2,
        P_TAIL_ADV,
        P_TAIL_CLOS
    } phase_t;

    function automatic logic is_term(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_LBRK) || (b == CH_COLON);
    endfunction

endpackage

// ----- src/gwm_store.sv -----
// gwm_store: pattern byte memory, one write and one registered read port
// reads at or past the effective length return zero; uses gwm_pkg
module gwm_store
    import gwm_pkg::*;
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [CW-1:0] rd_addr,
    input  logic [PW-1:0] limit,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [MAX_PATTERN];
    logic [7:0] mem_q_reg;
    logic       oob_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr[AW-1:0]];
            oob_reg   <= (rd_addr >= {1'b0, limit});
        end
    end

    assign rd_data = oob_reg ? 8'h00 : mem_q_reg;

endmodule

// ----- src/glob_wildcard_matcher.sv -----
// glob_wildcard_matcher: top level of the glob pattern matcher
// uses gwm_pkg and gwm_store
//
// Load a pattern with operation = 0 words (last marks its final byte), then
// send subject bytes with operation = 1; the word with last = 1 yields one
// verdict (0 match, 1 excluded by a leading '!', 2 no match). Matching runs
// a set of live pattern positions, stepped once per subject byte by a small
// sequencer around the single read port of the pattern memory. Per subject
// byte the sequencer sweeps the positions twice (star closure, then
// advance): a dead position is skipped in S_SCAN, a live one is read in
// S_OP (and S_ESC after a backslash), and a live bracket class walks its
// class bytes through the S_C_* states. The last byte adds up to len+1
// further sweep pairs over trailing zero bytes. in_ready is high only
// while the sequencer is idle; a finished verdict sits in an output
// register so new words are taken while it waits.
module glob_wildcard_matcher
    import gwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] char_code,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] verdict
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [PW-1:0]        q_reg, q_next;
    logic [PW-1:0]        k_reg, k_next;
    logic [MAX_PATTERN:0] live_reg, live_next;
    logic [MAX_PATTERN:0] nxt_reg, nxt_next;
    logic                 match_reg, match_next;
    logic [7:0]           b_reg, b_next;
    logic                 last_reg, last_next;
    logic [7:0]           cls_c_reg, cls_c_next;
    logic [CW-1:0]        cls_p_reg, cls_p_next;
    logic                 want_reg, want_next;
    logic                 seen_reg, seen_next;

    // pattern bookkeeping
    logic [PW-1:0] len_reg, len_next;     // bytes stored
    logic [PW-1:0] eff_reg, eff_next;     // length up to first zero byte
    logic          zs_reg, zs_next;       // zero byte already seen
    logic          bang_reg, bang_next;   // leading '!'
    logic          ovf_reg, ovf_next;
    logic          newpat_reg, newpat_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    verdict_reg, verdict_next;

    // memory ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic          advancing;
    logic [PW-1:0] q1, q2;
    logic [PW-1:0] idx;

    assign advancing = (phase_reg == P_ADV_B) || (phase_reg == P_TAIL_ADV);
    assign q1 = q_reg + PW'(1);
    assign q2 = q_reg + PW'(2);

    gwm_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (char_code),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .limit   (eff_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= P_CLOS1;
            q_reg         <= '0;
            k_reg         <= '0;
            live_reg      <= {{MAX_PATTERN{1'b0}}, 1'b1};
            nxt_reg       <= '0;
            match_reg     <= 1'b0;
            last_reg      <= 1'b0;
            len_reg       <= '0;
            eff_reg       <= '0;
            zs_reg        <= 1'b0;
            bang_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            newpat_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            q_reg         <= q_next;
            k_reg         <= k_next;
            live_reg      <= live_next;
            nxt_reg       <= nxt_next;
            match_reg     <= match_next;
            last_reg      <= last_next;
            len_reg       <= len_next;
            eff_reg       <= eff_next;
            zs_reg        <= zs_next;
            bang_reg      <= bang_next;
            ovf_reg       <= ovf_next;
            newpat_reg    <= newpat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        b_reg       <= b_next;
        cls_c_reg   <= cls_c_next;
        cls_p_reg   <= cls_p_next;
        want_reg    <= want_next;
        seen_reg    <= seen_next;
        verdict_reg <= verdict_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        q_next         = q_reg;
        k_next         = k_reg;
        live_next      = live_reg;
        nxt_next       = nxt_reg;
        match_next     = match_reg;
        b_next         = b_reg;
        last_next      = last_reg;
        cls_c_next     = cls_c_reg;
        cls_p_next     = cls_p_reg;
        want_next      = want_reg;
        seen_next      = seen_reg;
        len_next       = len_reg;
        eff_next       = eff_reg;
        zs_next        = zs_reg;
        bang_next      = bang_reg;
        ovf_next       = ovf_reg;
        newpat_next    = newpat_reg;
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        idx            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_LOAD)
                    begin
                        idx       = newpat_reg ? '0 : len_reg;
                        zs_next   = newpat_reg ? 1'b0 : zs_reg;
                        ovf_next  = newpat_reg ? 1'b0 : ovf_reg;
                        if (idx < PW'(MAX_PATTERN))
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = idx[AW-1:0];
                            len_next = idx + PW'(1);
                            if (!zs_next)
                            begin
                                if (char_code == 8'h00)
                                begin
                                    zs_next  = 1'b1;
                                    eff_next = idx;
                                end
                                else
                                begin
                                    eff_next = idx + PW'(1);
                                end
                            end
                            if (idx == '0)
                            begin
                                bang_next = (char_code == CH_BANG);
                            end
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        newpat_next = last;
                        // restart the subject
                        live_next = '0;
                        live_next[bang_next ? 1 : 0] = 1'b1;
                        match_next = 1'b0;
                    end
                    else
                    begin
                        b_next     = char_code;
                        last_next  = last;
                        phase_next = P_CLOS1;
                        q_next     = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if ((!advancing && q_reg >= eff_reg) || (advancing && q_reg > eff_reg))
                begin
                    // sweep finished
                    q_next     = '0;
                    state_next = S_SCAN;
                    case (phase_reg)
                        P_CLOS1:
                        begin
                            phase_next = P_ADV_B;
                            nxt_next   = '0;
                        end
                        P_ADV_B:
                        begin
                            live_next = nxt_reg;
                            if (!last_reg)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                phase_next = P_CLOS2;
                            end
                        end
                        P_CLOS2:
                        begin
                            k_next = '0;
                            if (match_reg)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                phase_next = P_TAIL_ADV;
                                b_next     = 8'h00;
                                nxt_next   = '0;
                            end
                        end
                        P_TAIL_ADV:
                        begin
                            live_next = nxt_reg;
                            if (nxt_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                phase_next = P_TAIL_CLOS;
                            end
                        end
                        default:
                        begin
                            k_next = k_reg + PW'(1);
                            if (match_reg || (k_next > eff_reg))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                phase_next = P_TAIL_ADV;
                                nxt_next   = '0;
                            end
                        end
                    endcase
                end
                else if (!live_reg[q_reg])
                begin
                    q_next = q1;
                end
                else if (advancing && q_reg == eff_reg)
                begin
                    // end of pattern reached
                    if (is_term(b_reg))
                    begin
                        match_next = 1'b1;
                    end
                    q_next = q1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {1'b0, q_reg};
                    state_next = S_OP;
                end
            end

            S_OP:
            begin
                state_next = S_SCAN;
                q_next     = q1;
                if (!advancing)
                begin
                    // star closure
                    if (rd_data == CH_STAR)
                    begin
                        if (q1 == eff_reg)
                        begin
                            match_next = 1'b1;
                        end
                        else
                        begin
                            live_next[q1] = 1'b1;
                        end
                    end
                end
                else
                begin
                    case (rd_data)
                        CH_STAR:
                        begin
                            if (!is_term(b_reg))
                            begin
                                nxt_next[q_reg] = 1'b1;
                            end
                        end
                        CH_QUEST:
                        begin
                            if (!is_term(b_reg))
                            begin
                                nxt_next[q1] = 1'b1;
                            end
                        end
                        CH_BSLSH:
                        begin
                            if (q1 < eff_reg)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = {1'b0, q1};
                                q_next     = q_reg;
                                state_next = S_ESC;
                            end
                        end
                        CH_LBRK:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = {1'b0, q1};
                            q_next     = q_reg;
                            seen_next  = 1'b0;
                            state_next = S_C_BANG;
                        end
                        default:
                        begin
                            if (rd_data == b_reg)
                            begin
                                nxt_next[q1] = 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_ESC:
            begin
                if (rd_data == b_reg)
                begin
                    nxt_next[q2] = 1'b1;
                end
                q_next     = q1;
                state_next = S_SCAN;
            end

            S_C_BANG:
            begin
                cls_p_next = {1'b0, q2};
                if (rd_data == CH_BANG)
                begin
                    want_next  = 1'b0;
                    rd_en      = 1'b1;
                    rd_addr    = {1'b0, q2};
                    state_next = S_C_FIRST;
                end
                else
                begin
                    want_next  = 1'b1;
                    cls_c_next = rd_data;
                    state_next = S_C_TOP;
                end
            end

            S_C_FIRST:
            begin
                cls_c_next = rd_data;
                cls_p_next = cls_p_reg + CW'(1);
                state_next = S_C_TOP;
            end

            S_C_TOP:
            begin
                if (cls_c_reg == 8'h00)
                begin
                    // unterminated class: path dies
                    q_next     = q1;
                    state_next = S_SCAN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cls_p_reg;
                    state_next = S_C_LOOK;
                end
            end

            S_C_LOOK:
            begin
                if (rd_data == CH_DASH)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cls_p_reg + CW'(1);
                    state_next = S_C_HI;
                end
                else
                begin
                    if (cls_c_reg == b_reg)
                    begin
                        seen_next = 1'b1;
                    end
                    cls_c_next = rd_data;
                    cls_p_next = cls_p_reg + CW'(1);
                    state_next = (rd_data == CH_RBRK) ? S_DONE : S_C_TOP;
                    if (rd_data == CH_RBRK)
                    begin
                        state_next = S_SCAN;
                        q_next     = q1;
                        if ((seen_next == want_reg) && (cls_p_next <= {1'b0, eff_reg}))
                        begin
                            nxt_next[cls_p_next[PW-1:0]] = 1'b1;
                        end
                    end
                end
            end

            S_C_HI:
            begin
                if (rd_data != 8'h00)
                begin
                    if ((b_reg >= cls_c_reg) && (b_reg <= rd_data))
                    begin
                        seen_next = 1'b1;
                    end
                    cls_p_next = cls_p_reg + CW'(2);
                    rd_en      = 1'b1;
                    rd_addr    = cls_p_next;
                    state_next = S_C_AFTER;
                end
                else
                begin
                    // dash before the end is a plain member
                    if (cls_c_reg == b_reg)
                    begin
                        seen_next = 1'b1;
                    end
                    cls_c_next = CH_DASH;
                    cls_p_next = cls_p_reg + CW'(1);
                    state_next = S_C_TOP;
                end
            end

            S_C_AFTER:
            begin
                cls_c_next = rd_data;
                cls_p_next = cls_p_reg + CW'(1);
                state_next = S_C_TOP;
                if (rd_data == CH_RBRK)
                begin
                    state_next = S_SCAN;
                    q_next     = q1;
                    if ((seen_reg == want_reg) && (cls_p_next <= {1'b0, eff_reg}))
                    begin
                        nxt_next[cls_p_next[PW-1:0]] = 1'b1;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (ovf_reg)
                    begin
                        verdict_next = VD_NOMATCH;
                    end
                    else if (bang_reg)
                    begin
                        verdict_next = match_reg ? VD_EXCLUDED : VD_MATCH;
                    end
                    else
                    begin
                        verdict_next = match_reg ? VD_MATCH : VD_NOMATCH;
                    end
                    live_next = '0;
                    live_next[bang_reg ? 1 : 0] = 1'b1;
                    match_next = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule
